// File: hdl/dht_pkg.sv
package dht_pkg;

  localparam int TABLE_SLOTS = 31;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 5;
  localparam int ENTRIES_W   = 5;
  localparam int RED_STEPS   = $clog2(KEY_W);
  localparam int TREE_N      = 2 ** RED_STEPS;
  localparam int SUM_W       = $clog2(KEY_W * (TABLE_SLOTS - 1) + 1);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_GONE  = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] stride;
  } dht_hash_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
  } dht_entry_t;

  function automatic int pow2_mod(int bit_pos, int modulus);
    int r;
    r = 1;
    for (int j = 0; j < bit_pos; j++) begin
      r = r * 2;
      if (r >= modulus) r = r - modulus;
    end
    return r;
  endfunction

endpackage

// File: hdl/dht_hash.sv
module dht_hash
  import dht_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output dht_hash_t        hash
);

  logic                            pend;
  logic [SUM_W-1:0]                sum_a;
  logic [SUM_W-1:0]                sum_b;
  logic [SUM_W-1:0]                sum_a_next;
  logic [SUM_W-1:0]                sum_b_next;
  logic [SUM_W-1:0]                tree_a [TREE_N];
  logic [SUM_W-1:0]                tree_b [TREE_N];
  logic [SLOT_W-1:0]               rem_a;
  logic [SLOT_W-1:0]               rem_b;
  logic [SLOT_W-1:0]               rem_a_next;
  logic [SLOT_W-1:0]               rem_b_next;

  always_comb begin
    for (int i = 0; i < KEY_W; i++) begin
      tree_a[i] = key[i] ? SUM_W'(pow2_mod(i, TABLE_SLOTS)) : '0;
      tree_b[i] = key[i] ? SUM_W'(pow2_mod(i, TABLE_SLOTS - 1)) : '0;
    end
    for (int i = KEY_W; i < TREE_N; i++) begin
      tree_a[i] = '0;
      tree_b[i] = '0;
    end
    for (int w = TREE_N >> 1; w >= 1; w = w >> 1) begin
      for (int i = 0; i < w; i++) begin
        tree_a[i] = tree_a[2*i] + tree_a[2*i+1];
        tree_b[i] = tree_b[2*i] + tree_b[2*i+1];
      end
    end
    sum_a_next = tree_a[0];
    sum_b_next = tree_b[0];
  end

  always_comb begin
    logic [SUM_W-1:0] ra;
    logic [SUM_W-1:0] rb;
    ra = sum_a;
    rb = sum_b;
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (ra >= SUM_W'(TABLE_SLOTS << k)) ra = ra - SUM_W'(TABLE_SLOTS << k);
      if (rb >= SUM_W'((TABLE_SLOTS - 1) << k)) rb = rb - SUM_W'((TABLE_SLOTS - 1) << k);
    end
    rem_a_next = ra[SLOT_W-1:0];
    rem_b_next = rb[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= start;
      done <= pend;
      if (start) begin
        sum_a <= sum_a_next;
        sum_b <= sum_b_next;
      end
      if (pend) begin
        rem_a <= rem_a_next;
        rem_b <= rem_b_next;
      end
    end
  end

  assign hash.base   = rem_a;
  assign hash.stride = rem_b + 1'b1;

endmodule

// File: hdl/double_hash_table.sv
// Channel  Dir  tdata (low bit first)                              tuser
// s_*      in   key[30:0], entry_value[62:31], zero pad to 64     operation[1:0]
// m_*      out  success[0], slot_index[5:1], found_value[37:6],   -
//               entries_used[42:38], zero pad to 48
// One request at a time: accept, then key reduction in registered steps (residue sum, then
// fold), then one probe per cycle through the slot memory (registered read), at most
// TABLE_SLOTS probes plus one, then the load of the result register.
// The probe walk over the slot memory sets how long a request takes.
// Synchronous reset clears all slot marks to empty and the entry count at once.
// s_tready is low while a request is in progress; a result waiting on m_tready holds
// only the load of the next result.
module double_hash_table
  import dht_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [63:0]     s_tdata,   // key, entry_value
  input  logic [OP_W-1:0] s_tuser,   // operation
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [47:0]     m_tdata    // success, slot_index, found_value, entries_used
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HASH  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]           state;
  logic [OP_W-1:0]      op;
  logic [KEY_W-1:0]     key;
  logic [VAL_W-1:0]     val;
  logic [CNT_W-1:0]     occ;
  logic [1:0]           marks [TABLE_SLOTS];
  dht_entry_t           mem   [TABLE_SLOTS];
  dht_entry_t           rd_entry;
  logic [1:0]           rd_mark;
  logic [SLOT_W-1:0]    rd_slot;
  logic                 rd_last;
  logic                 rd_valid;
  logic [SLOT_W-1:0]    issue_slot;
  logic [SLOT_W-1:0]    issue_slot_next;
  logic [CNT_W-1:0]     issue_cnt;
  logic [SLOT_W-1:0]    stride;
  logic                 res_success;
  logic [SLOT_W-1:0]    res_slot;
  logic [VAL_W-1:0]     res_value;
  logic                 mem_we;
  logic                 hash_start;
  logic                 hash_done;
  dht_hash_t            hash;
  logic                 used;
  logic                 match;
  logic                 take;
  logic                 found;
  logic                 miss;
  logic                 accept;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign hash_start = accept;

  dht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (s_tdata[KEY_W-1:0]),
    .done  (hash_done),
    .hash  (hash)
  );

  always_comb begin
    logic [SLOT_W:0] sum;
    sum = {1'b0, issue_slot} + {1'b0, stride};
    if (sum >= (SLOT_W+1)'(TABLE_SLOTS)) sum = sum - (SLOT_W+1)'(TABLE_SLOTS);
    issue_slot_next = sum[SLOT_W-1:0];
  end

  assign used   = (rd_mark == MARK_USED);
  assign match  = used && (rd_entry.key == key);
  assign take   = !used || match;
  assign found  = match;
  assign miss   = (rd_mark == MARK_EMPTY) || (rd_last && !match);
  assign mem_we = (state == ST_PROBE) && rd_valid && (op == OP_INSERT) && take;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[rd_slot] <= '{value: val, key: key};
    end
    rd_entry <= mem[issue_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      occ      <= '0;
      rd_valid <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        marks[i] <= MARK_EMPTY;
      end
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op    <= s_tuser;
            key   <= s_tdata[KEY_W-1:0];
            val   <= s_tdata[KEY_W+VAL_W-1:KEY_W];
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            res_success <= 1'b0;
            res_slot    <= '0;
            res_value   <= '0;
            issue_slot  <= hash.base;
            stride      <= hash.stride;
            issue_cnt   <= '0;
            rd_valid    <= 1'b0;
            if ((op != OP_INSERT && op != OP_SEARCH && op != OP_REMOVE) ||
                (op == OP_INSERT && occ == CNT_W'(TABLE_SLOTS))) begin
              state <= ST_DONE;
            end else begin
              state <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          rd_valid   <= 1'b1;
          rd_mark    <= marks[issue_slot];
          rd_slot    <= issue_slot;
          rd_last    <= (issue_cnt == CNT_W'(TABLE_SLOTS - 1));
          issue_slot <= issue_slot_next;
          issue_cnt  <= issue_cnt + 1'b1;
          if (rd_valid) begin
            if (op == OP_INSERT) begin
              if (take) begin
                marks[rd_slot] <= MARK_USED;
                if (!used) occ <= occ + 1'b1;
                res_success <= 1'b1;
                res_slot    <= rd_slot;
                state       <= ST_DONE;
              end else if (rd_last) begin
                state <= ST_DONE;
              end
            end else begin
              if (found) begin
                res_success <= 1'b1;
                res_slot    <= rd_slot;
                if (op == OP_SEARCH) begin
                  res_value <= rd_entry.value;
                end else begin
                  marks[rd_slot] <= MARK_GONE;
                  occ            <= occ - 1'b1;
                end
                state <= ST_DONE;
              end else if (miss) begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          rd_valid <= 1'b0;
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, ENTRIES_W'(occ), res_value, INDEX_W'(res_slot), res_success};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(TABLE_SLOTS))
    else $error("entry count above table size");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (occ == $past(occ) || occ == $past(occ) + 1'b1 || occ == $past(occ) - 1'b1))
    else $error("entry count moved by more than one");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_PROBE && op == OP_INSERT))
    else $error("slot write outside insert probe");

  a_hash_state: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == ST_HASH))
    else $error("hash finished outside hash state");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[5:1] == '0 && m_tdata[37:6] == '0))
    else $error("failed result carries slot or value");
`endif

endmodule

// File: tb/double_hash_table_test.sv
module double_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dht_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 1190;
  localparam int POOL_SIZE = 40;

  typedef struct packed {
    logic                 success;
    logic [INDEX_W-1:0]   slot_index;
    logic [VAL_W-1:0]     found_value;
    logic [ENTRIES_W-1:0] entries_used;
  } reply_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               typed;
    reply_t           want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = OP_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  logic [KEY_W-1:0] tbl_keys[TABLE_SLOTS];
  logic [VAL_W-1:0] tbl_values[TABLE_SLOTS];
  logic [1:0]       tbl_marks[TABLE_SLOTS];
  int unsigned      tbl_count;

  reply_t           replies_due[$];
  script_row_t      script[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int               mismatches = 0;
  int               requests_sent = 0;
  int               send_idle_pct = 19;
  int               recv_idle_pct = 84;
  int               stall_cycles = 0;

  double_hash_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned probe_at(logic [KEY_W-1:0] key, int unsigned p);
    int unsigned k;
    k = key;
    return (k % TABLE_SLOTS + p * (1 + k % (TABLE_SLOTS - 1))) % TABLE_SLOTS;
  endfunction

  function automatic bit find_key(logic [KEY_W-1:0] key, output int unsigned where);
    int unsigned s;
    where = 0;
    for (int p = 0; p < TABLE_SLOTS; p++) begin
      s = probe_at(key, p);
      if (tbl_marks[s] == MARK_EMPTY) return 1'b0;
      if (tbl_marks[s] == MARK_USED && tbl_keys[s] == key) begin
        where = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic reply_t hash_table_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                              logic [VAL_W-1:0] value);
    reply_t      r;
    int unsigned s;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (tbl_count < TABLE_SLOTS) begin
          for (int p = 0; p < TABLE_SLOTS; p++) begin
            s = probe_at(key, p);
            if (tbl_marks[s] != MARK_USED || tbl_keys[s] == key) begin
              if (tbl_marks[s] != MARK_USED) tbl_count++;
              tbl_keys[s]   = key;
              tbl_values[s] = value;
              tbl_marks[s]  = MARK_USED;
              r.success     = 1'b1;
              r.slot_index  = INDEX_W'(s);
              break;
            end
          end
        end
      end
      OP_SEARCH: begin
        if (find_key(key, s)) begin
          r.success     = 1'b1;
          r.slot_index  = INDEX_W'(s);
          r.found_value = tbl_values[s];
        end
      end
      OP_REMOVE: begin
        if (find_key(key, s)) begin
          tbl_marks[s] = MARK_GONE;
          if (tbl_count > 0) tbl_count--;
          r.success    = 1'b1;
          r.slot_index = INDEX_W'(s);
        end
      end
      default: begin
      end
    endcase
    r.entries_used = ENTRIES_W'(tbl_count);
    return r;
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                  logic [VAL_W-1:0] value, bit typed, logic success,
                                  int slot, logic [VAL_W-1:0] fval, int used);
    script_row_t row;
    row.op    = op;
    row.key   = key;
    row.value = value;
    row.typed = typed;
    row.want  = '{success, INDEX_W'(slot), fval, ENTRIES_W'(used)};
    script.insert(script.size(), row);
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value, input bit typed,
                              input reply_t want);
    reply_t due;
    if (requests_sent < 420) begin
      send_idle_pct = 19;
      recv_idle_pct = 84;
    end else if (requests_sent < 840) begin
      send_idle_pct = 84;
      recv_idle_pct = 19;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, value, key};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    due = hash_table_apply(op, key, value);
    if (typed) due = want;
    replies_due.insert(replies_due.size(), due);
    requests_sent++;
  endtask

  task automatic check_reply(input logic [47:0] data);
    reply_t got;
    reply_t due;
    got.success      = data[0];
    got.slot_index   = data[5:1];
    got.found_value  = data[37:6];
    got.entries_used = data[42:38];
    if (replies_due.size() == 0) begin
      $display("%0t: unexpected reply: success=%0d slot=%0d value=%h used=%0d", $time,
               got.success, got.slot_index, got.found_value, got.entries_used);
      mismatches++;
    end else begin
      due = replies_due.pop_front();
      if (got != due) begin
        $display("%0t: reply mismatch: expected success=%0d slot=%0d value=%h used=%0d",
                 $time, due.success, due.slot_index, due.found_value, due.entries_used);
        $display("%0t:                 actual   success=%0d slot=%0d value=%h used=%0d",
                 $time, got.success, got.slot_index, got.found_value, got.entries_used);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_reply(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("double_hash_table_test: done, errors");
      $finish;
    end
  end

  initial begin
    int          r;
    bit          insert_heavy;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    reply_t      none;

    none = '0;
    tbl_count = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) tbl_marks[i] = MARK_EMPTY;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 8) key_pool[i] = KEY_W'(i * TABLE_SLOTS);
      else if (i < 16) key_pool[i] = KEY_W'($urandom_range(TABLE_SLOTS - 1));
      else key_pool[i] = KEY_W'($urandom);
    end
    key_pool[16] = '0;
    key_pool[17] = '1;

    add_row(OP_SEARCH, 31'd5, 32'h0, 1, 1'b0, 0, 32'h0, 0);
    add_row(OP_REMOVE, 31'd5, 32'h0, 1, 1'b0, 0, 32'h0, 0);
    add_row(OP_UNUSED, 31'd7, 32'h1234_5678, 1, 1'b0, 0, 32'h0, 0);
    add_row(OP_INSERT, 31'd0, 32'h0, 1, 1'b1, 0, 32'h0, 1);
    add_row(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 1, 32'h0, 2);
    add_row(OP_SEARCH, 31'd0, 32'h0, 1, 1'b1, 0, 32'h0, 2);
    add_row(OP_SEARCH, 31'h7FFF_FFFF, 32'h0, 1, 1'b1, 1, 32'hFFFF_FFFF, 2);
    add_row(OP_INSERT, 31'd0, 32'hA5A5_A5A5, 1, 1'b1, 0, 32'h0, 2);
    add_row(OP_SEARCH, 31'd0, 32'h0, 1, 1'b1, 0, 32'hA5A5_A5A5, 2);
    add_row(OP_INSERT, 31'd31, 32'h0000_0031, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_INSERT, 31'd62, 32'h0000_0062, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_REMOVE, 31'd0, 32'h0, 1, 1'b1, 0, 32'h0, 3);
    add_row(OP_SEARCH, 31'd0, 32'h0, 1, 1'b0, 0, 32'h0, 3);
    add_row(OP_SEARCH, 31'd31, 32'h0, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_SEARCH, 31'd62, 32'h0, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_INSERT, 31'd93, 32'h5A5A_5A5A, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_REMOVE, 31'd0, 32'h0, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_INSERT, 31'd30, 32'h1234_5678, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_SEARCH, 31'd30, 32'h0, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_REMOVE, 31'h7FFF_FFFF, 32'h0, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_SEARCH, 31'h7FFF_FFFF, 32'h0, 0, 1'b0, 0, 32'h0, 0);
    add_row(OP_REMOVE, 31'd62, 32'h0, 0, 1'b0, 0, 32'h0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_request(script[i].op, script[i].key, script[i].value,
                                     script[i].typed, script[i].want);

    // fill up, then hit the full table with insert, search and remove
    while (tbl_count < TABLE_SLOTS)
      send_request(OP_INSERT, KEY_W'($urandom_range(2000)), $urandom, 0, none);
    send_request(OP_INSERT, tbl_keys[5], $urandom, 0, none);
    send_request(OP_INSERT, 31'h7FFF_FFFE, $urandom, 0, none);
    send_request(OP_SEARCH, 31'h7FFF_FFFE, $urandom, 0, none);
    send_request(OP_SEARCH, tbl_keys[17], $urandom, 0, none);
    key = tbl_keys[17];
    send_request(OP_REMOVE, key, $urandom, 0, none);
    send_request(OP_INSERT, key, $urandom, 0, none);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      insert_heavy = ((i / 150) % 2) == 0;
      r = $urandom_range(99);
      if (insert_heavy)
        op = (r < 65) ? OP_INSERT : (r < 85) ? OP_SEARCH : (r < 97) ? OP_REMOVE : OP_UNUSED;
      else
        op = (r < 25) ? OP_INSERT : (r < 55) ? OP_SEARCH : (r < 95) ? OP_REMOVE : OP_UNUSED;
      if ($urandom_range(99) < 80) key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else key = KEY_W'($urandom);
      send_request(op, key, $urandom, 0, none);
    end

    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("double_hash_table_test: done, clean");
    end else begin
      $display("double_hash_table_test: done, errors");
    end
    $finish;
  end

endmodule
